@@ hdl/ssfc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared types, codes and constants for the SPSC slot FIFO controller.
// ----------------------------------------------------------------------------
package ssfc_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned TKT_W    = 32;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned NUM_EV   = 7;

  // Defaults and limits
  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned CAP_MAX       = 2047;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CAP_W-1:0] PEAK_MAX  = CAP_W'(2047);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLAIM   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUBLISH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ABORT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACQUIRE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RESET   = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NODATA  = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;

  // Event counter indexes
  localparam int unsigned EV_PUBLISH = 0;
  localparam int unsigned EV_CONSUME = 1;
  localparam int unsigned EV_FULL    = 2;
  localparam int unsigned EV_EMPTY   = 3;
  localparam int unsigned EV_ABORT   = 4;
  localparam int unsigned EV_RESET   = 5;
  localparam int unsigned EV_ERROR   = 6;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TKT_W-1:0]  ticket_value;
    logic [SLOT_W-1:0] ticket_slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] granted_slot;
    logic [TKT_W-1:0]  granted_ticket;
    logic [CAP_W-1:0]  occupancy;
    logic [CAP_W-1:0]  peak_occupancy;
    logic [CNT_W-1:0]  publish_count;
    logic [CNT_W-1:0]  consume_count;
    logic [CNT_W-1:0]  full_count;
    logic [CNT_W-1:0]  empty_count;
    logic [CNT_W-1:0]  abort_count;
    logic [CNT_W-1:0]  reset_count;
    logic [CNT_W-1:0]  error_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture accepted item
    logic exec;      // apply the action to the ring state
    logic load_out;  // fill the result register
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

@@ hdl/ssfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssfc_ctrl
// Sequencer: accept an item, execute it, then hand it to the result register.
// ----------------------------------------------------------------------------
module ssfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfc_pkg::cmd_t    cmd
);

  ssfc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == ssfc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ssfc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ssfc_pkg::S_EXEC;
        end
      end
      ssfc_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ssfc_pkg::S_FIN;
      end
      ssfc_pkg::S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ssfc_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssfc_pkg::S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssfc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accepted item is always executed in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.exec)
    else $error("accepted item not executed");

  // result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // every load of the result register follows an execute
  a_load_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(cmd.load_out) && $past(rst_n)) |-> $past(cmd.exec) || $past(state_r == ssfc_pkg::S_FIN))
    else $error("result without execute");

endmodule

@@ hdl/ssfc_dp.sv @@
// ----------------------------------------------------------------------------
// ssfc_dp
// Ring state, ticket checks, peak tracking, event counters, result register.
// ----------------------------------------------------------------------------
module ssfc_dp #(
  parameter int unsigned MAX_SLOTS = ssfc_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssfc_pkg::cmd_t                cmd,
  input  logic                          cfg_we,
  input  logic [ssfc_pkg::CAP_W-1:0]    cfg_wdata,
  input  ssfc_pkg::in_item_t            in_item,
  output ssfc_pkg::out_item_t           out_item
);

  localparam int unsigned CAP_W = ssfc_pkg::CAP_W;
  localparam int unsigned POS_W = ssfc_pkg::POS_W;
  localparam int unsigned TKT_W = ssfc_pkg::TKT_W;
  localparam int unsigned CNT_W = ssfc_pkg::CNT_W;
  localparam int unsigned NUM_EV = ssfc_pkg::NUM_EV;
  localparam int unsigned LIM_INT =
    (MAX_SLOTS > ssfc_pkg::CAP_MAX) ? ssfc_pkg::CAP_MAX : MAX_SLOTS;
  localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(LIM_INT);

  // configuration and ring state
  logic [CAP_W-1:0]  cap_r;
  logic [POS_W-1:0]  wpos_r, wpos_nxt, rpos_r, rpos_nxt;
  logic [CAP_W-1:0]  wslot_r, wslot_nxt, rslot_r, rslot_nxt;
  logic [TKT_W-1:0]  wtkt_r, wtkt_nxt, rtkt_r, rtkt_nxt;
  logic              wheld_r, wheld_nxt, rheld_r, rheld_nxt;
  logic [CAP_W-1:0]  peak_r, peak_nxt;
  logic [CNT_W-1:0]  cnt_r [NUM_EV];
  logic [NUM_EV-1:0] bump;

  // latched item and per-item result parts
  ssfc_pkg::in_item_t          item_r;
  logic [ssfc_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [CAP_W-1:0]            gslot_r, gslot_nxt;
  logic [TKT_W-1:0]            gtkt_r, gtkt_nxt;
  ssfc_pkg::out_item_t         out_r;

  logic [CAP_W-1:0] cap_eff;
  logic [POS_W-1:0] depth, pub_depth;
  logic [CAP_W-1:0] pub_peak;
  logic [CAP_W-1:0] occ;
  logic [TKT_W-1:0] wtkt_inc, rtkt_inc;
  logic [CAP_W:0]   wslot_inc, rslot_inc;
  logic [CAP_W-1:0] tslot_x;
  logic             wmatch, rmatch;

  // effective capacity: zero acts as one, clamp to the ring size
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_LIM) begin
      cap_eff = CAP_LIM;
    end else begin
      cap_eff = cap_r;
    end
  end

  assign depth     = wpos_r - rpos_r;
  assign pub_depth = depth + POS_W'(1);
  assign pub_peak  = (pub_depth > POS_W'(ssfc_pkg::PEAK_MAX)) ?
                     ssfc_pkg::PEAK_MAX : pub_depth[CAP_W-1:0];
  assign occ       = (depth > POS_W'(cap_eff)) ? cap_eff : depth[CAP_W-1:0];

  // next ticket skips zero; ring index wraps at capacity
  assign wtkt_inc  = (wtkt_r + TKT_W'(1) == '0) ? TKT_W'(1) : wtkt_r + TKT_W'(1);
  assign rtkt_inc  = (rtkt_r + TKT_W'(1) == '0) ? TKT_W'(1) : rtkt_r + TKT_W'(1);
  assign wslot_inc = {1'b0, wslot_r} + (CAP_W+1)'(1);
  assign rslot_inc = {1'b0, rslot_r} + (CAP_W+1)'(1);

  assign tslot_x = CAP_W'(item_r.ticket_slot);
  assign wmatch  = wheld_r && (item_r.ticket_value != '0) &&
                   (item_r.ticket_value == wtkt_r) && (tslot_x == wslot_r);
  assign rmatch  = rheld_r && (item_r.ticket_value != '0) &&
                   (item_r.ticket_value == rtkt_r) && (tslot_x == rslot_r);

  // action decode
  always_comb begin
    wpos_nxt  = wpos_r;
    rpos_nxt  = rpos_r;
    wslot_nxt = wslot_r;
    rslot_nxt = rslot_r;
    wtkt_nxt  = wtkt_r;
    rtkt_nxt  = rtkt_r;
    wheld_nxt = wheld_r;
    rheld_nxt = rheld_r;
    peak_nxt  = peak_r;
    stat_nxt  = ssfc_pkg::ST_OK;
    gslot_nxt = '0;
    gtkt_nxt  = '0;
    bump      = '0;
    unique case (item_r.action)
      ssfc_pkg::ACT_CLAIM: begin
        if (wheld_r) begin
          stat_nxt = ssfc_pkg::ST_BUSY;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else if (depth >= POS_W'(cap_eff)) begin
          stat_nxt = ssfc_pkg::ST_FULL;
          bump[ssfc_pkg::EV_FULL] = 1'b1;
        end else begin
          wtkt_nxt  = wtkt_inc;
          wheld_nxt = 1'b1;
          gslot_nxt = wslot_r;
          gtkt_nxt  = wtkt_inc;
        end
      end
      ssfc_pkg::ACT_PUBLISH: begin
        if (!wmatch) begin
          stat_nxt = ssfc_pkg::ST_INVALID;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else begin
          wpos_nxt  = wpos_r + POS_W'(1);
          wslot_nxt = (wslot_inc >= {1'b0, cap_eff}) ? '0 : wslot_inc[CAP_W-1:0];
          wheld_nxt = 1'b0;
          if (pub_peak > peak_r) begin
            peak_nxt = pub_peak;
          end
          bump[ssfc_pkg::EV_PUBLISH] = 1'b1;
        end
      end
      ssfc_pkg::ACT_ABORT: begin
        if (!wmatch) begin
          stat_nxt = ssfc_pkg::ST_INVALID;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else begin
          wheld_nxt = 1'b0;
          bump[ssfc_pkg::EV_ABORT] = 1'b1;
        end
      end
      ssfc_pkg::ACT_ACQUIRE: begin
        if (rheld_r) begin
          stat_nxt = ssfc_pkg::ST_BUSY;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else if (rpos_r == wpos_r) begin
          stat_nxt = ssfc_pkg::ST_NODATA;
          bump[ssfc_pkg::EV_EMPTY] = 1'b1;
        end else begin
          rtkt_nxt  = rtkt_inc;
          rheld_nxt = 1'b1;
          gslot_nxt = rslot_r;
          gtkt_nxt  = rtkt_inc;
        end
      end
      ssfc_pkg::ACT_RELEASE: begin
        if (!rmatch) begin
          stat_nxt = ssfc_pkg::ST_INVALID;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else begin
          rpos_nxt  = rpos_r + POS_W'(1);
          rslot_nxt = (rslot_inc >= {1'b0, cap_eff}) ? '0 : rslot_inc[CAP_W-1:0];
          rheld_nxt = 1'b0;
          bump[ssfc_pkg::EV_CONSUME] = 1'b1;
        end
      end
      ssfc_pkg::ACT_RESET: begin
        if (wheld_r || rheld_r) begin
          stat_nxt = ssfc_pkg::ST_BUSY;
          bump[ssfc_pkg::EV_ERROR] = 1'b1;
        end else begin
          wpos_nxt  = '0;
          rpos_nxt  = '0;
          wslot_nxt = '0;
          rslot_nxt = '0;
          bump[ssfc_pkg::EV_RESET] = 1'b1;
        end
      end
      default: begin
        stat_nxt = ssfc_pkg::ST_INVALID;
      end
    endcase
  end

  // control state: configuration, ring, tickets, peak, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= ssfc_pkg::CAP_RESET;
      wpos_r  <= '0;
      rpos_r  <= '0;
      wslot_r <= '0;
      rslot_r <= '0;
      wtkt_r  <= '0;
      rtkt_r  <= '0;
      wheld_r <= 1'b0;
      rheld_r <= 1'b0;
      peak_r  <= '0;
      for (int i = 0; i < NUM_EV; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        wpos_r  <= wpos_nxt;
        rpos_r  <= rpos_nxt;
        wslot_r <= wslot_nxt;
        rslot_r <= rslot_nxt;
        wtkt_r  <= wtkt_nxt;
        rtkt_r  <= rtkt_nxt;
        wheld_r <= wheld_nxt;
        rheld_r <= rheld_nxt;
        peak_r  <= peak_nxt;
        for (int i = 0; i < NUM_EV; i++) begin
          if (bump[i] && (cnt_r[i] != '1)) begin
            cnt_r[i] <= cnt_r[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      stat_r  <= stat_nxt;
      gslot_r <= gslot_nxt;
      gtkt_r  <= gtkt_nxt;
    end
    if (cmd.load_out) begin
      out_r.status         <= stat_r;
      out_r.granted_slot   <= gslot_r[ssfc_pkg::SLOT_W-1:0];
      out_r.granted_ticket <= gtkt_r;
      out_r.occupancy      <= occ;
      out_r.peak_occupancy <= peak_r;
      out_r.publish_count  <= cnt_r[ssfc_pkg::EV_PUBLISH];
      out_r.consume_count  <= cnt_r[ssfc_pkg::EV_CONSUME];
      out_r.full_count     <= cnt_r[ssfc_pkg::EV_FULL];
      out_r.empty_count    <= cnt_r[ssfc_pkg::EV_EMPTY];
      out_r.abort_count    <= cnt_r[ssfc_pkg::EV_ABORT];
      out_r.reset_count    <= cnt_r[ssfc_pkg::EV_RESET];
      out_r.error_count    <= cnt_r[ssfc_pkg::EV_ERROR];
    end
  end

  assign out_item = out_r;

  // an action moves at most one event counter
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bump))
    else $error("more than one event counted");

  // the peak never drops
  a_peak_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (peak_r >= $past(peak_r)))
    else $error("peak decreased");

  // ring state only moves when an item executes
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.exec) |=> ($stable(wpos_r) && $stable(rpos_r) && $stable(wheld_r) &&
                     $stable(rheld_r)))
    else $error("ring state changed without execute");

endmodule

@@ hdl/spsc_slot_fifo_controller_core.sv @@
// ----------------------------------------------------------------------------
// spsc_slot_fifo_controller_core
// Slot-ownership controller for a single-producer single-consumer ring FIFO.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    ssfc_pkg::in_item_t
//   out_     output     out_valid / out_ready  ssfc_pkg::out_item_t
//   cfg_     input      cfg_we (no wait)       slot capacity, 11 bits
//
// Each item passes three steps: capture, execute, load of the result
// register; the sequencer in ssfc_ctrl sets this order.
// The next item is accepted while a result still waits in the output register.
// A stalled output holds only the final step; the result register drains first.
// rst_n is synchronous; it sets the capacity to 16 and zeroes the control state.
// ----------------------------------------------------------------------------
module spsc_slot_fifo_controller_core #(
  parameter int unsigned MAX_SLOTS = ssfc_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssfc_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssfc_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [ssfc_pkg::CAP_W-1:0]   cfg_wdata
);

  ssfc_pkg::cmd_t cmd;

  ssfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ssfc_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item)
  );

endmodule
